// File: hdl/lmbc_pkg.sv
// ----------------------------------------------------------------------------
// lmbc_pkg
// Shared types and constants of the axis linear map and Bezier curve block.
// ----------------------------------------------------------------------------
`default_nettype none

package lmbc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CTRL_W     = 16;
    localparam int CTRL_FRAC  = 15;
    localparam int Q1_W       = 16;
    localparam int VAL_W      = Q1_W + 1;
    localparam int RNG_W      = 16;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL_Y   = 3'd4;

    localparam logic [CFG_DATA_W-1:0] MAP_MIN_RESET = 16'h8001;
    localparam logic [CFG_DATA_W-1:0] MAP_MAX_RESET = 16'h7FFF;
    localparam logic [CTRL_W-1:0]     CTRL_Y_RESET  = 16'h4000;

    typedef enum logic [1:0] {
        TSEL_DIV,
        TSEL_ZERO,
        TSEL_ONE
    } tsel_t;

    typedef struct packed {
        tsel_t                     tsel;
        logic                      out_neg;
        logic [RNG_W-1:0]          rng;
        logic signed [VAL_W-1:0]   v;
    } curve_pay_t;

endpackage

`default_nettype wire

// File: hdl/lmbc_div_cell.sv
// ----------------------------------------------------------------------------
// lmbc_div_cell
// One restoring division step: produces one quotient bit and hands the
// partial remainder, the shifted dividend and the payload to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module lmbc_div_cell #(
    parameter int REM_W = 16,
    parameter int Q_W   = 16,
    parameter int PAY_W = 1
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              en,
    input  wire              in_valid,
    input  wire  [REM_W-1:0] in_rem,
    input  wire  [Q_W-1:0]   in_dq,
    input  wire  [REM_W-1:0] in_div,
    input  wire  [PAY_W-1:0] in_pay,
    output logic             out_valid,
    output logic [REM_W-1:0] out_rem,
    output logic [Q_W-1:0]   out_dq,
    output logic [REM_W-1:0] out_div,
    output logic [PAY_W-1:0] out_pay
);

    logic             valid_reg;
    logic [REM_W-1:0] rem_reg;
    logic [Q_W-1:0]   dq_reg;
    logic [REM_W-1:0] div_reg;
    logic [PAY_W-1:0] pay_reg;

    logic [REM_W:0]   cat;
    logic [REM_W+1:0] trial;
    logic             take;
    logic [REM_W-1:0] rem_next;
    logic [Q_W-1:0]   dq_next;

    always_comb begin
        cat      = {in_rem, in_dq[Q_W-1]};
        trial    = {1'b0, cat} - {2'b00, in_div};
        take     = ~trial[REM_W+1];
        rem_next = take ? trial[REM_W-1:0] : cat[REM_W-1:0];
        dq_next  = {in_dq[Q_W-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
            div_reg <= in_div;
            pay_reg <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_dq    = dq_reg;
    assign out_div   = div_reg;
    assign out_pay   = pay_reg;

endmodule

`default_nettype wire

// File: hdl/lmbc_div_row.sv
// ----------------------------------------------------------------------------
// lmbc_div_row
// A row of division cells, one quotient bit per cell, one word per cycle while en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module lmbc_div_row #(
    parameter int REM_W = 16,
    parameter int Q_W   = 16,
    parameter int PAY_W = 1
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              en,
    input  wire              in_valid,
    input  wire  [REM_W-1:0] in_rem,
    input  wire  [Q_W-1:0]   in_dq,
    input  wire  [REM_W-1:0] in_div,
    input  wire  [PAY_W-1:0] in_pay,
    output logic             out_valid,
    output logic [Q_W-1:0]   out_quo,
    output logic [PAY_W-1:0] out_pay
);

    logic             valid_w [0:Q_W];
    logic [REM_W-1:0] rem_w   [0:Q_W];
    logic [Q_W-1:0]   dq_w    [0:Q_W];
    logic [REM_W-1:0] div_w   [0:Q_W];
    logic [PAY_W-1:0] pay_w   [0:Q_W];

    assign valid_w[0] = in_valid;
    assign rem_w[0]   = in_rem;
    assign dq_w[0]    = in_dq;
    assign div_w[0]   = in_div;
    assign pay_w[0]   = in_pay;

    for (genvar i = 0; i < Q_W; i++) begin : g_cell
        lmbc_div_cell #(
            .REM_W (REM_W),
            .Q_W   (Q_W),
            .PAY_W (PAY_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (valid_w[i]),
            .in_rem    (rem_w[i]),
            .in_dq     (dq_w[i]),
            .in_div    (div_w[i]),
            .in_pay    (pay_w[i]),
            .out_valid (valid_w[i+1]),
            .out_rem   (rem_w[i+1]),
            .out_dq    (dq_w[i+1]),
            .out_div   (div_w[i+1]),
            .out_pay   (pay_w[i+1])
        );
    end

    assign out_valid = valid_w[Q_W];
    assign out_quo   = dq_w[Q_W];
    assign out_pay   = pay_w[Q_W];

endmodule

`default_nettype wire

// File: hdl/lmbc_curve.sv
// ----------------------------------------------------------------------------
// lmbc_curve
// Quadratic Bezier response y = 2t(1-t)c + t^2, scaled back by the range,
// saturated and signed; with curve_en low the payload value passes unchanged. Six register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module lmbc_curve
    import lmbc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     en,
    input  wire                     curve_en,
    input  wire  [CTRL_W-1:0]       ctrl_y,
    input  wire                     in_valid,
    input  wire  [FRAC_BITS-1:0]    in_quo,
    input  wire  curve_pay_t        in_pay,
    output logic                    out_valid,
    output logic signed [VAL_W-1:0] out_value
);

    localparam int T_W   = FRAC_BITS + 1;
    localparam int TU_W  = 2 * FRAC_BITS + 2;
    localparam int HI_W  = TU_W - FRAC_BITS;
    localparam int LO_P  = FRAC_BITS + CTRL_W;
    localparam int HI_P  = HI_W + CTRL_W;
    localparam int YN_W  = 2 * FRAC_BITS + 17;
    localparam int YQ_W  = FRAC_BITS + 2;
    localparam int PM_W  = YQ_W + RNG_W;
    localparam int RES_W = PM_W - FRAC_BITS;
    localparam logic [T_W-1:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic [5:0] valid_reg;

    logic [T_W-1:0]  t_next, u_next;
    logic [T_W-1:0]  k1_t_reg, k1_u_reg;
    logic [TU_W-1:0] k2_tu_reg, k2_t2_reg;
    logic [LO_P-1:0] k3_plo_reg;
    logic [HI_P-1:0] k3_phi_reg;
    logic [TU_W-1:0] k3_t2_reg;
    logic [YN_W-1:0] ynum;
    logic [YQ_W-1:0] k4_yq_reg;
    logic [PM_W-1:0] k5_pmag_reg;
    logic [RES_W-1:0] res;
    logic [RNG_W-1:0] sat;
    logic signed [VAL_W-1:0] value_next;
    logic signed [VAL_W-1:0] value_reg;

    curve_pay_t k1_pay_reg, k2_pay_reg, k3_pay_reg, k4_pay_reg, k5_pay_reg;

    always_comb begin
        unique case (in_pay.tsel)
            TSEL_ONE:  t_next = T_ONE;
            TSEL_ZERO: t_next = '0;
            TSEL_DIV:  t_next = {1'b0, in_quo};
            default:   t_next = '0;
        endcase
        u_next = T_ONE - t_next;
    end

    assign ynum = (YN_W'(k3_phi_reg) << (FRAC_BITS + 1))
                + (YN_W'(k3_plo_reg) << 1)
                + (YN_W'(k3_t2_reg) << CTRL_FRAC);

    always_comb begin
        res = k5_pmag_reg[PM_W-1:FRAC_BITS];
        sat = (|res[RES_W-1:RNG_W]) ? {RNG_W{1'b1}} : res[RNG_W-1:0];
        if (curve_en) begin
            value_next = k5_pay_reg.out_neg ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
        end else begin
            value_next = k5_pay_reg.v;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k1_t_reg    <= t_next;
            k1_u_reg    <= u_next;
            k1_pay_reg  <= in_pay;
            k2_tu_reg   <= k1_t_reg * k1_u_reg;
            k2_t2_reg   <= k1_t_reg * k1_t_reg;
            k2_pay_reg  <= k1_pay_reg;
            k3_plo_reg  <= k2_tu_reg[FRAC_BITS-1:0] * ctrl_y;
            k3_phi_reg  <= k2_tu_reg[TU_W-1:FRAC_BITS] * ctrl_y;
            k3_t2_reg   <= k2_t2_reg;
            k3_pay_reg  <= k2_pay_reg;
            k4_yq_reg   <= ynum[YN_W-1 -: YQ_W];
            k4_pay_reg  <= k3_pay_reg;
            k5_pmag_reg <= k4_yq_reg * k4_pay_reg.rng;
            k5_pay_reg  <= k4_pay_reg;
            value_reg   <= value_next;
        end
    end

    assign out_valid = valid_reg[5];
    assign out_value = value_reg;

endmodule

`default_nettype wire

// File: hdl/axis_linear_map_bezier_curve.sv
// ----------------------------------------------------------------------------
// axis_linear_map_bezier_curve
// Joystick axis shaping: linear range map, optional reversal and optional
// quadratic Bezier response curve, one sample in and one value out.
// Throughput: one word per cycle while the output buffer has room; two division rows of one bit per cell
// (16 cells, then FRAC_BITS cells) set the depth, not the rate.
// Reset: synchronous, active low; clears all valid bits and the output
// buffer and loads the register defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module axis_linear_map_bezier_curve
    import lmbc_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    // s_axis_tdata: [15:0] raw_sample
    input  wire                     s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire  [IN_TDATA_W-1:0]   s_axis_tdata,
    // m_axis_tdata: [16:0] shaped_value, [23:17] zero
    output logic                    m_axis_tvalid,
    input  wire                     m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    input  wire                     cfg_valid,
    output logic                    cfg_ready,
    input  wire  [CFG_IDX_W-1:0]    cfg_index,
    input  wire  [CFG_DATA_W-1:0]   cfg_data
);

    localparam int NUM_W    = SAMPLE_BITS + 18;
    localparam int MAG1_W   = NUM_W - 1;
    localparam int PB_W     = SAMPLE_BITS + 17;
    localparam int AXIS_MAX = 2 ** (SAMPLE_BITS - 1) - 1;
    localparam int DEN      = 2 * AXIS_MAX;
    localparam logic [SAMPLE_BITS-1:0] DEN_V = SAMPLE_BITS'(DEN);
    localparam int PAY2_W   = $bits(curve_pay_t);

    // Configuration registers and values derived from them.
    logic signed [CFG_DATA_W-1:0] map_min_reg, map_max_reg;
    logic                         reverse_reg, curve_reg;
    logic [CTRL_W-1:0]            ctrl_y_reg;
    logic signed [VAL_W-1:0]      range_lin_reg;
    logic                         spans_reg;

    logic adv;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_min_reg <= MAP_MIN_RESET;
            map_max_reg <= MAP_MAX_RESET;
            reverse_reg <= 1'b0;
            curve_reg   <= 1'b0;
            ctrl_y_reg  <= CTRL_Y_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_MAP_MIN: map_min_reg <= cfg_data;
                REG_MAP_MAX: map_max_reg <= cfg_data;
                REG_REVERSE: reverse_reg <= cfg_data[0];
                REG_CURVE:   curve_reg   <= cfg_data[0];
                REG_CTRL_Y:  ctrl_y_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        range_lin_reg <= {map_max_reg[CFG_DATA_W-1], map_max_reg}
                       - {map_min_reg[CFG_DATA_W-1], map_min_reg};
        spans_reg     <= map_min_reg[CFG_DATA_W-1] && !map_max_reg[CFG_DATA_W-1]
                       && (map_max_reg != '0);
    end

    // Input stage: clamp the sample and offset it to 0..2*AXIS_MAX.
    logic [SAMPLE_BITS-1:0] offset_bin, a_off_next, a_off_reg;

    assign offset_bin = {~s_axis_tdata[SAMPLE_BITS-1], s_axis_tdata[SAMPLE_BITS-2:0]};
    assign a_off_next = (offset_bin == '0) ? '0 : offset_bin - 1'b1;

    // Linear map numerator, then sign and magnitude for the first row.
    logic signed [NUM_W-1:0] pa_next, pa_reg, num_next, num_reg;
    logic signed [PB_W-1:0]  pb_next, pb_reg;
    logic [NUM_W-1:0]        num_abs;
    logic                    r1_sgn_reg;
    logic [MAG1_W-1:0]       r1_mag_reg;

    assign pa_next  = $signed({1'b0, a_off_reg}) * range_lin_reg;
    assign pb_next  = map_min_reg * $signed({1'b0, DEN_V});
    assign num_next = pa_reg + {{(NUM_W - PB_W){pb_reg[PB_W-1]}}, pb_reg};
    assign num_abs  = num_reg[NUM_W-1] ? (~num_reg + 1'b1) : num_reg;

    logic [4:0] pre_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_valid_reg <= '0;
        end else if (adv) begin
            pre_valid_reg[0] <= s_axis_tvalid;
            pre_valid_reg[1] <= pre_valid_reg[0];
            pre_valid_reg[2] <= pre_valid_reg[1];
            pre_valid_reg[3] <= pre_valid_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_off_reg  <= a_off_next;
            pa_reg     <= pa_next;
            pb_reg     <= pb_next;
            num_reg    <= num_next;
            r1_sgn_reg <= num_reg[NUM_W-1];
            r1_mag_reg <= num_abs[MAG1_W-1:0];
        end
    end

    logic            d1_valid;
    logic [Q1_W-1:0] d1_quo;
    logic [0:0]      d1_pay;

    lmbc_div_row #(
        .REM_W (SAMPLE_BITS),
        .Q_W   (Q1_W),
        .PAY_W (1)
    ) u_map_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (pre_valid_reg[3]),
        .in_rem    (r1_mag_reg[Q1_W +: SAMPLE_BITS]),
        .in_dq     (r1_mag_reg[Q1_W-1:0]),
        .in_div    (DEN_V),
        .in_pay    (r1_sgn_reg),
        .out_valid (d1_valid),
        .out_quo   (d1_quo),
        .out_pay   (d1_pay)
    );

    // Mapped value, reversal, then curve operands.
    logic signed [VAL_W-1:0] m_next, a_m_reg, v_next, b_v_reg, c1_v_reg;
    logic signed [VAL_W-1:0] v_abs, min_neg, rlin_abs;
    logic                    vneg;
    logic [RNG_W-1:0]        mag_next, rng_next, c1_mag_reg, c1_rng_reg;
    logic                    qneg_next, oneg_next, c1_qneg_reg, c1_oneg_reg;
    tsel_t                   tsel_next;
    logic [RNG_W-1:0]        r2_mag_reg, r2_rng_reg;
    curve_pay_t              r2_pay_reg;
    logic [3:0]              mid_valid_reg;

    assign m_next = d1_pay[0] ? -$signed({1'b0, d1_quo}) : $signed({1'b0, d1_quo});
    assign v_next = reverse_reg ? ({map_max_reg[CFG_DATA_W-1], map_max_reg} - a_m_reg)
                                : a_m_reg;

    always_comb begin
        vneg     = b_v_reg[VAL_W-1];
        v_abs    = vneg ? -b_v_reg : b_v_reg;
        min_neg  = -{map_min_reg[CFG_DATA_W-1], map_min_reg};
        rlin_abs = range_lin_reg[VAL_W-1] ? -range_lin_reg : range_lin_reg;
        mag_next = v_abs[RNG_W-1:0];
        if (spans_reg) begin
            rng_next  = vneg ? min_neg[RNG_W-1:0] : map_max_reg;
            qneg_next = 1'b0;
            oneg_next = vneg;
        end else begin
            rng_next  = rlin_abs[RNG_W-1:0];
            qneg_next = vneg ^ range_lin_reg[VAL_W-1];
            oneg_next = range_lin_reg[VAL_W-1];
        end
    end

    always_comb begin
        if (c1_rng_reg == '0) begin
            tsel_next = TSEL_ZERO;
        end else if (c1_qneg_reg && (c1_mag_reg != '0)) begin
            tsel_next = TSEL_ZERO;
        end else if (c1_mag_reg >= c1_rng_reg) begin
            tsel_next = TSEL_ONE;
        end else begin
            tsel_next = TSEL_DIV;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= '0;
        end else if (adv) begin
            mid_valid_reg <= {mid_valid_reg[2:0], d1_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_m_reg            <= m_next;
            b_v_reg            <= v_next;
            c1_v_reg           <= b_v_reg;
            c1_mag_reg         <= mag_next;
            c1_rng_reg         <= rng_next;
            c1_qneg_reg        <= qneg_next;
            c1_oneg_reg        <= oneg_next;
            r2_mag_reg         <= c1_mag_reg;
            r2_rng_reg         <= c1_rng_reg;
            r2_pay_reg.tsel    <= tsel_next;
            r2_pay_reg.out_neg <= c1_oneg_reg;
            r2_pay_reg.rng     <= c1_rng_reg;
            r2_pay_reg.v       <= c1_v_reg;
        end
    end

    logic                 d2_valid;
    logic [FRAC_BITS-1:0] d2_quo;
    logic [PAY2_W-1:0]    d2_pay;

    lmbc_div_row #(
        .REM_W (RNG_W),
        .Q_W   (FRAC_BITS),
        .PAY_W (PAY2_W)
    ) u_t_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (mid_valid_reg[3]),
        .in_rem    (r2_mag_reg),
        .in_dq     ('0),
        .in_div    (r2_rng_reg),
        .in_pay    (r2_pay_reg),
        .out_valid (d2_valid),
        .out_quo   (d2_quo),
        .out_pay   (d2_pay)
    );

    logic                    k_valid;
    logic signed [VAL_W-1:0] k_value;

    lmbc_curve #(
        .FRAC_BITS (FRAC_BITS)
    ) u_curve (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .curve_en  (curve_reg),
        .ctrl_y    (ctrl_y_reg),
        .in_valid  (d2_valid),
        .in_quo    (d2_quo),
        .in_pay    (curve_pay_t'(d2_pay)),
        .out_valid (k_valid),
        .out_value (k_value)
    );

    // Two-word output buffer; the pipeline advances while it has room.
    logic [1:0]       cnt_reg;
    logic [VAL_W-1:0] e0_reg, e1_reg;
    logic             push, pop;

    assign adv           = (cnt_reg != 2'd2);
    assign push          = adv && k_valid;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = {{(OUT_TDATA_W - VAL_W){1'b0}}, e0_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push && pop) begin
            if (cnt_reg == 2'd1) begin
                e0_reg <= k_value;
            end else begin
                e0_reg <= e1_reg;
                e1_reg <= k_value;
            end
        end else if (push) begin
            if (cnt_reg == 2'd0) begin
                e0_reg <= k_value;
            end else begin
                e1_reg <= k_value;
            end
        end else if (pop) begin
            e0_reg <= e1_reg;
        end
    end

endmodule

`default_nettype wire

// File: hdl/lmbc_checker.sv
// ----------------------------------------------------------------------------
// lmbc_checker
// Port-level checks of the axis linear map and Bezier curve block.
// ----------------------------------------------------------------------------
`default_nettype none

module lmbc_checker
    import lmbc_pkg::*;
(
    input wire                    aclk,
    input wire                    aresetn,
    input wire                    s_axis_tvalid,
    input wire                    s_axis_tready,
    input wire [IN_TDATA_W-1:0]   s_axis_tdata,
    input wire                    m_axis_tvalid,
    input wire                    m_axis_tready,
    input wire [OUT_TDATA_W-1:0]  m_axis_tdata,
    input wire                    cfg_valid,
    input wire                    cfg_ready,
    input wire [CFG_IDX_W-1:0]    cfg_index,
    input wire [CFG_DATA_W-1:0]   cfg_data
);

    // Reset empties the output buffer.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result word present after reset");

    // The input side leaves reset ready to take a word.
    a_reset_ready: assert property (@(posedge aclk)
        $rose(aresetn) |-> s_axis_tready)
        else $error("input not ready after reset");

    // Back-pressure on the input only comes from results waiting at the output.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result waiting");

    // A stalled result word holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // Shaped values stay within -65535..65535 and the padding is zero.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:VAL_W] == '0)
                          && (m_axis_tdata[VAL_W-1:0] != 17'h10000))
        else $error("shaped value out of range");

endmodule

bind axis_linear_map_bezier_curve lmbc_checker u_lmbc_checker (.*);

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the joystick axis shaping block. Raw samples are sent
// under random source gaps and sink stalls. Every result word is compared
// against a local fixed-point model of the map, reverse and Bezier stages.
// Each phase after the first loads a register set while the block is idle. Phases cover
// directed corner settings and then random settings.
// ----------------------------------------------------------------------------

module testbench;

    import lmbc_pkg::*;

    localparam int      FRAC         = 16;
    localparam int      LATENCY      = FRAC + 30;
    localparam int      STALL_LIMIT  = 4000;
    localparam int      RAND_PHASES  = 12;
    localparam int      PHASE_ITEMS  = 112;
    localparam int      REG_IDX_LAST = (1 << CFG_IDX_W) - 1;
    localparam longint  AXIS_MAX     = 32767;
    localparam longint  T_ONE        = longint'(1) << FRAC;
    localparam longint  OUT_MAX      = 65535;

    typedef struct {
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        logic                  rev;
        logic                  crv;
        logic [CTRL_W-1:0]     ctrl;
    } shape_cfg_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    // Local copy of the register file.
    longint          map_lo;
    longint          map_hi;
    bit              rev_on;
    bit              curve_on;
    longint unsigned ctrl_y;

    logic [IN_TDATA_W-1:0] sample_q[$];
    logic [VAL_W-1:0]      shaped_q[$];
    int samples_queued = 0;
    int samples_taken  = 0;
    int err_cnt        = 0;
    int idle_cycles    = 0;
    int in_gap         = 0;
    int in_calm        = 0;
    int out_stall      = 0;
    int out_calm       = 0;
    logic                  next_valid;
    logic [VAL_W-1:0]      want;
    logic [OUT_TDATA_W-1:0] want_word;

    axis_linear_map_bezier_curve DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [VAL_W-1:0] shape_axis(input logic [IN_TDATA_W-1:0] raw);
        longint          a, den, v, rng, mag, tq, yq, prod, pmag, res;
        longint unsigned tt, uu, ynum;
        bit              spans, neg, rneg;
        a = longint'($signed(raw));
        if (a < -AXIS_MAX) a = -AXIS_MAX;
        den = 2 * AXIS_MAX;
        v = (map_lo * den + (a + AXIS_MAX) * (map_hi - map_lo)) / den;
        if (rev_on) v = map_hi - v;
        if (curve_on) begin
            spans = (map_lo < 0) && (map_hi > 0);
            neg   = spans && (v < 0);
            if (spans) begin
                rng = neg ? -map_lo : map_hi;
                mag = (v < 0) ? -v : v;
            end else begin
                rng = map_hi - map_lo;
                mag = v;
            end
            if (rng == 0) begin
                tq = 0;
            end else begin
                tq = (mag * T_ONE) / rng;
                if (tq < 0) tq = 0;
                if (tq > T_ONE) tq = T_ONE;
            end
            tt   = longint'(tq);
            uu   = longint'(T_ONE - tq);
            ynum = 2 * tt * uu * ctrl_y + ((tt * tt) << CTRL_FRAC);
            yq   = longint'(ynum >> (FRAC + CTRL_FRAC));
            prod = yq * rng;
            rneg = prod < 0;
            pmag = rneg ? -prod : prod;
            res  = pmag >> FRAC;
            v    = (rneg != neg) ? -res : res;
        end
        if (v > OUT_MAX) v = OUT_MAX;
        if (v < -OUT_MAX) v = -OUT_MAX;
        return v[VAL_W-1:0];
    endfunction

    // Mostly short gaps, a few long ones, and now and then a stretch without any.
    function automatic int next_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 60) == 0) calm = $urandom_range(30, 100);
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic logic [15:0] pick_word16();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h8001;
            2: return 16'hFFFF;
            3: return 16'h0000;
            4: return 16'h0001;
            5: return 16'h7FFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MAP_MIN: map_lo   = longint'($signed(data));
            REG_MAP_MAX: map_hi   = longint'($signed(data));
            REG_REVERSE: rev_on   = data[0];
            REG_CURVE:   curve_on = data[0];
            REG_CTRL_Y:  ctrl_y   = data;
            default: ;
        endcase
    endtask

    task automatic load_settings(input shape_cfg_t c);
        write_reg(REG_MAP_MIN, c.lo);
        write_reg(REG_MAP_MAX, c.hi);
        write_reg(REG_REVERSE, {{(CFG_DATA_W-1){1'b0}}, c.rev});
        write_reg(REG_CURVE, {{(CFG_DATA_W-1){1'b0}}, c.crv});
        write_reg(REG_CTRL_Y, c.ctrl);
    endtask

    task automatic send_sample(input logic [IN_TDATA_W-1:0] raw);
        sample_q.push_back(raw);
        samples_queued++;
    endtask

    task automatic wait_drained();
        do @(posedge aclk); while (samples_taken != samples_queued || shaped_q.size() != 0);
    endtask

    // Source side: one word per handshake, then a random gap.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            in_gap = 0;
        end else begin
            next_valid = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                shaped_q.push_back(shape_axis(s_axis_tdata));
                samples_taken++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (sample_q.size() > 0) begin
                    s_axis_tdata <= sample_q.pop_front();
                    next_valid = 1'b1;
                    in_gap = next_gap(in_calm);
                end
            end
            s_axis_tvalid <= next_valid;
        end
    end

    // Sink side: compare each result word with the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            out_stall = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (shaped_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("Unexpected result word %h with nothing pending.",
                                 m_axis_tdata);
                end else begin
                    want      = shaped_q.pop_front();
                    want_word = {{(OUT_TDATA_W-VAL_W){1'b0}}, want};
                    if (m_axis_tdata !== want_word) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("Mismatch: shaped_value expected %0d (%h), got %h.",
                                     $signed(want), want_word, m_axis_tdata);
                    end
                end
            end
            if (out_stall > 0) begin
                out_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                out_stall = next_gap(out_calm);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        shape_cfg_t c;
        map_lo   = longint'($signed(MAP_MIN_RESET));
        map_hi   = longint'($signed(MAP_MAX_RESET));
        rev_on   = 1'b0;
        curve_on = 1'b0;
        ctrl_y   = CTRL_Y_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings, including the most negative sample.
        send_sample(16'h8000);
        send_sample(16'h8001);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'h7FFF);
        wait_drained();

        // Full range around zero with the control point at its top code.
        c = '{lo: 16'h8000, hi: 16'h7FFF, rev: 1'b0, crv: 1'b1, ctrl: 16'hFFFF};
        load_settings(c);
        send_sample(16'h8000);
        send_sample(16'hC000);
        send_sample(16'h4000);
        send_sample(16'h7FFF);
        wait_drained();

        // Inverted full range, reversed: the curve pushes past the output limit.
        c = '{lo: 16'h7FFF, hi: 16'h8000, rev: 1'b1, crv: 1'b1, ctrl: 16'hFFFF};
        load_settings(c);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'h7FFF);
        send_sample(16'hD556);
        wait_drained();

        // Negative range with positive values: t falls below zero.
        c = '{lo: 16'h0064, hi: 16'hFF9C, rev: 1'b0, crv: 1'b1, ctrl: 16'h8000};
        load_settings(c);
        send_sample(16'h8001);
        send_sample(16'h7FFF);
        send_sample(16'h0000);
        wait_drained();

        // Zero range.
        c = '{lo: 16'h03E8, hi: 16'h03E8, rev: 1'b1, crv: 1'b1, ctrl: 16'h4000};
        load_settings(c);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        wait_drained();

        // Writes to unused register indexes must change nothing.
        c = '{lo: 16'h0000, hi: 16'h7FFF, rev: 1'b0, crv: 1'b1, ctrl: 16'h0000};
        load_settings(c);
        write_reg(REG_CTRL_Y + 1, 16'hA5A5);
        write_reg(REG_IDX_LAST, 16'h5A5A);
        send_sample(16'h8001);
        send_sample(16'h3FFF);
        send_sample(16'h7FFF);
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++) begin
            c.lo   = pick_word16();
            c.hi   = pick_word16();
            c.rev  = $urandom_range(0, 1);
            c.crv  = $urandom_range(0, 2) != 0;
            case ($urandom_range(0, 7))
                0: c.ctrl = 16'h0000;
                1: c.ctrl = CTRL_Y_RESET;
                2: c.ctrl = 16'h8000;
                3: c.ctrl = 16'hFFFF;
                default: c.ctrl = 16'($urandom_range(0, 65535));
            endcase
            load_settings(c);
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_IDX_W'($urandom_range(REG_CTRL_Y + 1, REG_IDX_LAST)),
                          16'($urandom_range(0, 65535)));
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 9) == 0)
                    send_sample(pick_word16());
                else
                    send_sample(16'($urandom_range(0, 65535)));
            end
            wait_drained();
        end

        repeat (2 * LATENCY) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/lmbc_pkg.sv
hdl/lmbc_div_cell.sv
hdl/lmbc_div_row.sv
hdl/lmbc_curve.sv
hdl/axis_linear_map_bezier_curve.sv
hdl/lmbc_checker.sv
tb/testbench.sv
